@@ hw/rtl/hrhp_pkg.sv @@
// Shared types, codes and lookup functions for the HTTP request head parser.
package hrhp_pkg;

  localparam int unsigned BUF_BYTES = 7;
  localparam int unsigned VER_LEN = 8;
  localparam int unsigned VER_SAT = 9;
  localparam int unsigned QDEPTH = 4;

  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_QM = 8'h3F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE = 8'h31;

  localparam logic [3:0] M_INVALID = 4'd0;
  localparam logic [3:0] M_GET = 4'd1;
  localparam logic [3:0] M_POST = 4'd2;
  localparam logic [3:0] M_HEAD = 4'd3;
  localparam logic [3:0] M_PUT = 4'd4;
  localparam logic [3:0] M_DELETE = 4'd5;
  localparam logic [3:0] M_CONNECT = 4'd6;
  localparam logic [3:0] M_OPTIONS = 4'd7;
  localparam logic [3:0] M_TRACE = 4'd8;

  localparam logic [1:0] V_NONE = 2'd0;
  localparam logic [1:0] V_10 = 2'd1;
  localparam logic [1:0] V_11 = 2'd2;

  localparam logic [55:0] NAME_GET = 56'h474554;
  localparam logic [55:0] NAME_POST = 56'h504F5354;
  localparam logic [55:0] NAME_HEAD = 56'h48454144;
  localparam logic [55:0] NAME_PUT = 56'h505554;
  localparam logic [55:0] NAME_DELETE = 56'h44454C455445;
  localparam logic [55:0] NAME_CONNECT = 56'h434F4E4E454354;
  localparam logic [55:0] NAME_OPTIONS = 56'h4F5054494F4E53;
  localparam logic [55:0] NAME_TRACE = 56'h5452414345;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_PATH,
    PH_QUERY,
    PH_VERSION,
    PH_HNAME,
    PH_HVALUE,
    PH_ERROR,
    PH_DONE
  } phase_e;

  typedef enum logic [3:0] {
    K_SEP       = 4'd0,
    K_METHOD    = 4'd1,
    K_PATH      = 4'd2,
    K_QUERY     = 4'd3,
    K_VERSION   = 4'd4,
    K_HNAME     = 4'd5,
    K_HVALUE    = 4'd6,
    K_LINE_OK   = 4'd7,
    K_HDR_END   = 4'd8,
    K_HEAD_DONE = 4'd9,
    K_ERROR     = 4'd10,
    K_UNPARSED  = 4'd11
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [3:0]  mcode;
    logic [1:0]  vcode;
    logic        last;
  } result_t;

  function automatic logic [3:0] method_lookup(input logic [55:0] mbuf,
                                               input logic [2:0] mlen);
    logic [3:0] code;
    code = M_INVALID;
    case (mlen)
      3'd3: begin
        if (mbuf == NAME_GET) code = M_GET;
        else if (mbuf == NAME_PUT) code = M_PUT;
      end
      3'd4: begin
        if (mbuf == NAME_POST) code = M_POST;
        else if (mbuf == NAME_HEAD) code = M_HEAD;
      end
      3'd5: begin
        if (mbuf == NAME_TRACE) code = M_TRACE;
      end
      3'd6: begin
        if (mbuf == NAME_DELETE) code = M_DELETE;
      end
      3'd7: begin
        if (mbuf == NAME_CONNECT) code = M_CONNECT;
        else if (mbuf == NAME_OPTIONS) code = M_OPTIONS;
      end
      default: code = M_INVALID;
    endcase
    return code;
  endfunction

  // "HTTP/1." one character per position
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h48;
      3'd1: c = 8'h54;
      3'd2: c = 8'h54;
      3'd3: c = 8'h50;
      3'd4: c = 8'h2F;
      3'd5: c = 8'h31;
      3'd6: c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/http_request_head_parser.sv @@
// Throughput: one byte per cycle while the result queue holds two entries or fewer;
// a bare CR released by a byte other than CR or LF gives two results, which
// leave the four-entry queue at one result per cycle while out_ready_i is high.
// The parse state updates in one short pass of logic at each byte transfer.
// Reset (rst_ni low) returns the parser to the method field and empties the queue.
// Restart on a byte does the same for the parse state before that byte.
module http_request_head_parser import hrhp_pkg::*; #(
  parameter int unsigned MAX_METHOD_CHARS = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       restart_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [3:0] method_code_o,
  output logic [1:0] version_code_o,
  output logic       last_o
);

  localparam int unsigned LenW = $clog2(MAX_METHOD_CHARS + 2);
  localparam int unsigned QAW = $clog2(QDEPTH);
  localparam int unsigned QCW = $clog2(QDEPTH + 1);

  typedef struct packed {
    phase_e          phase;
    logic [55:0]     mbuf;
    logic [LenW-1:0] mlen;
    logic [3:0]      vcnt;
    logic            vok;
    logic [7:0]      vlast;
    logic            cr;
    logic            colon;
  } pstate_t;

  typedef struct packed {
    pstate_t st;
    kind_e   kind;
  } step_t;

  localparam pstate_t ST_RESET = '{
    phase: PH_METHOD, mbuf: '0, mlen: '0, vcnt: '0, vok: 1'b1,
    vlast: '0, cr: 1'b0, colon: 1'b0
  };

  function automatic step_t field_step(input pstate_t s, input logic [7:0] b);
    step_t r;
    r.st = s;
    r.kind = K_HVALUE;
    case (s.phase)
      PH_METHOD: begin
        if (b == CH_SP) begin
          r.st.phase = PH_PATH;
          r.kind = K_SEP;
        end else begin
          if (s.mlen < LenW'(BUF_BYTES)) r.st.mbuf = {s.mbuf[47:0], b};
          if (s.mlen <= LenW'(MAX_METHOD_CHARS)) r.st.mlen = s.mlen + LenW'(1);
          r.kind = K_METHOD;
        end
      end
      PH_PATH: begin
        if (b == CH_SP) begin
          r.st.phase = PH_VERSION;
          r.kind = K_SEP;
        end else if (b == CH_QM) begin
          r.st.phase = PH_QUERY;
          r.kind = K_QUERY;
        end else begin
          r.kind = K_PATH;
        end
      end
      PH_QUERY: begin
        if (b == CH_SP) begin
          r.st.phase = PH_VERSION;
          r.kind = K_SEP;
        end else begin
          r.kind = K_QUERY;
        end
      end
      PH_VERSION: begin
        if (s.vcnt < 4'(BUF_BYTES) && b != prefix_char(s.vcnt[2:0])) r.st.vok = 1'b0;
        if (s.vcnt < 4'(VER_SAT)) r.st.vcnt = s.vcnt + 4'd1;
        r.st.vlast = b;
        r.kind = K_VERSION;
      end
      PH_HNAME: begin
        if (b == CH_COLON) begin
          r.st.phase = PH_HVALUE;
          r.st.colon = 1'b1;
          r.kind = K_SEP;
        end else begin
          r.kind = K_HNAME;
        end
      end
      default: r.kind = K_HVALUE;
    endcase
    return r;
  endfunction

  pstate_t st_q, st_d, s0, s1;
  step_t   step_cr, step_b;
  result_t res0, res1;
  logic [1:0] nres;
  logic [3:0] mc;
  logic [1:0] vc;
  logic       in_xfer, out_xfer;

  result_t          q_mem [QDEPTH];
  logic [QAW-1:0]   wr_q, rd_q;
  logic [QCW-1:0]   cnt_q;

  assign in_xfer  = in_valid_i & in_ready_o;
  assign out_xfer = out_valid_o & out_ready_i;

  always_comb begin
    s0 = restart_i ? ST_RESET : st_q;
    step_cr = field_step(s0, CH_CR);
    s1 = s0.cr ? step_cr.st : s0;
    s1.cr = 1'b0;
    step_b = field_step(s1, data_byte_i);
    mc = (s0.mlen != '0 && s0.mlen <= LenW'(BUF_BYTES)) ?
         method_lookup(s0.mbuf, s0.mlen[2:0]) : M_INVALID;
    vc = (s0.vlast == CH_ONE) ? V_11 : (s0.vlast == CH_ZERO) ? V_10 : V_NONE;

    st_d = s0;
    nres = 2'd0;
    res0 = '{kind: K_SEP, data: data_byte_i, mcode: M_INVALID, vcode: V_NONE,
             last: 1'b1};
    res1 = res0;

    if (s0.phase == PH_ERROR) begin
      nres = 2'd0;
    end else if (s0.phase == PH_DONE) begin
      res0.kind = K_UNPARSED;
      nres = 2'd1;
    end else if (s0.cr && data_byte_i == CH_LF) begin
      st_d.cr = 1'b0;
      st_d.colon = 1'b0;
      res0.data = '0;
      nres = 2'd1;
      if (s0.phase == PH_HNAME || s0.phase == PH_HVALUE) begin
        if (s0.colon) begin
          res0.kind = K_HDR_END;
          st_d.phase = PH_HNAME;
        end else begin
          res0.kind = K_HEAD_DONE;
          st_d.phase = PH_DONE;
        end
      end else if (s0.phase == PH_VERSION && mc != M_INVALID &&
                   s0.vcnt == 4'(VER_LEN) && s0.vok && vc != V_NONE) begin
        res0.kind = K_LINE_OK;
        res0.mcode = mc;
        res0.vcode = vc;
        st_d.phase = PH_HNAME;
      end else begin
        res0.kind = K_ERROR;
        st_d.phase = PH_ERROR;
      end
    end else begin
      if (data_byte_i == CH_CR) begin
        st_d = s1;
        st_d.cr = 1'b1;
      end else begin
        st_d = step_b.st;
      end
      if (s0.cr) begin
        res0.kind = step_cr.kind;
        res0.data = CH_CR;
        res0.last = (data_byte_i == CH_CR);
        res1.kind = step_b.kind;
        nres = (data_byte_i == CH_CR) ? 2'd1 : 2'd2;
      end else begin
        res0.kind = step_b.kind;
        nres = (data_byte_i == CH_CR) ? 2'd0 : 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_RESET;
    end else if (in_xfer) begin
      st_q <= st_d;
    end
  end

  // result queue
  assign in_ready_o  = cnt_q <= QCW'(QDEPTH - 2);
  assign out_valid_o = cnt_q != '0;

  always_ff @(posedge clk_i) begin
    if (in_xfer && nres != 2'd0) q_mem[wr_q] <= res0;
    if (in_xfer && nres == 2'd2) q_mem[wr_q + QAW'(1)] <= res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in_xfer) wr_q <= wr_q + QAW'(nres);
      if (out_xfer) rd_q <= rd_q + QAW'(1);
      cnt_q <= cnt_q + (in_xfer ? QCW'(nres) : '0) - QCW'(out_xfer);
    end
  end

  assign kind_o         = q_mem[rd_q].kind;
  assign out_byte_o     = q_mem[rd_q].data;
  assign method_code_o  = q_mem[rd_q].mcode;
  assign version_code_o = q_mem[rd_q].vcode;
  assign last_o         = q_mem[rd_q].last;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCW'(QDEPTH)) else $error("result queue overflow");

  a_codes_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (method_code_o != M_INVALID || version_code_o != V_NONE)
    |-> kind_o == K_LINE_OK) else $error("codes outside line ok result");

  a_verdict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == K_LINE_OK || kind_o == K_HDR_END ||
                    kind_o == K_HEAD_DONE || kind_o == K_ERROR)
    |-> out_byte_o == '0 && last_o) else $error("verdict result malformed");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PH_DONE && in_xfer && !restart_i |=> st_q.phase == PH_DONE)
    else $error("left head done without restart");

  a_error_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PH_ERROR && in_xfer && !restart_i |-> nres == 2'd0)
    else $error("result in error phase");
`endif

endmodule
